// ===== sv/assert_macros.svh =====
// Assertion macros shared by the text console writer RTL.
// Depends on nothing; the using module must provide i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define TCW_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// An implication checked at every clock edge outside reset.
`define TCW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
// Depends on nothing; used by every other file of the block but assert_macros.svh.
package tcw_pkg;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int CELLS       = SCREEN_ROWS * SCREEN_COLS;
    localparam int ADDR_W      = $clog2(CELLS);

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int REQ_W  = 2;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TOGGLE  = 8'h23;

    localparam logic [REQ_W-1:0] REQ_STRING = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RAW    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_TOGGLE,
        OP_NEWLINE,
        OP_CHAR,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_cmd;

    // Command handed from the front end to the queue, and queue head to the back end.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_slot;

    typedef struct packed {
        logic [CHAR_W-1:0] normal;
        logic [CHAR_W-1:0] bright;
    } t_attr;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic              bright_on;
        logic              did_scroll;
        logic [CHAR_W-1:0] cell_char;
        logic [CHAR_W-1:0] cell_attr;
    } t_res;

endpackage

// ===== sv/tcw_if.sv =====
// Request and result channel interfaces of the text console writer.
// Depends on tcw_pkg for the field widths.
interface tcw_req_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;

    modport source (output valid, req_type, char_code, read_row, read_col, input ready);
    modport sink   (input valid, req_type, char_code, read_row, read_col, output ready);
endinterface

interface tcw_res_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              bright_on;
    logic              did_scroll;
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_attr;

    modport source (output valid, cursor_col, cursor_row, bright_on, did_scroll,
                    cell_char, cell_attr, input ready);
    modport sink   (input valid, cursor_col, cursor_row, bright_on, did_scroll,
                    cell_char, cell_attr, output ready);
endinterface

// ===== sv/text_console_writer_top.sv =====
// A put's result passes the queue entry and the result register; a read also passes ST_READ
// for the registered cell-memory read. Throughput: one put per cycle while the queue is not
// full and results are taken; a read holds the back end in ST_READ, a scroll in ST_CLEAR while
// one 80-cell row is cleared. Reset: synchronous, active low. After reset a pass clears the cell
// memory, one cell per cycle; no request is accepted until it ends; register writes are taken.
// Top level of the text console writer; depends on tcw_pkg, tcw_if and the tcw_* modules.
module text_console_writer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcw_req_if.sink     i_req,
    tcw_res_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tcw_pkg::*;

    // Register index decoded from the word address bit.
    localparam logic REG_ATTR_NORMAL = 1'b0;
    localparam logic REG_ATTR_BRIGHT = 1'b1;

    // The two attribute bytes live here and feed the back end as one group.
    t_attr r_attr;
    t_slot w_push;
    t_slot w_head;
    logic  w_full;
    logic  w_pop;
    logic  w_busy;
    logic  w_cfg_write;

    // Every transfer on the configuration port completes in its access cycle.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr.normal <= 8'd7;
            r_attr.bright <= 8'd15;
        end else if (w_cfg_write) begin
            unique case (paddr[2])
                REG_ATTR_NORMAL: r_attr.normal <= pwdata[CHAR_W-1:0];
                REG_ATTR_BRIGHT: r_attr.bright <= pwdata[CHAR_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ATTR_NORMAL: prdata = {24'd0, r_attr.normal};
            REG_ATTR_BRIGHT: prdata = {24'd0, r_attr.bright};
        endcase
    end

    // The front end classifies each request as it is accepted; it refuses
    // transfers while the queue is full or the memory clear after reset runs.
    tcw_front u_front (
        .i_req  (i_req),
        .i_full (w_full),
        .i_busy (w_busy),
        .o_push (w_push)
    );

    // The queue lets the front end keep accepting while the back end
    // is held by a read, a row clear or a stalled result.
    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    // The back end owns the screen. Scrolling rotates the physical row shown
    // on top instead of moving cells, so only the new bottom row is cleared.
    tcw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_attr  (r_attr),
        .o_pop   (w_pop),
        .o_busy  (w_busy),
        .o_res   (o_res)
    );

endmodule

// ===== sv/tcw_front.sv =====
// Front end: accepts requests and reduces them to back-end commands.
// Depends on tcw_pkg and tcw_req_if.
module tcw_front (
    tcw_req_if.sink       i_req,
    input  logic          i_full,
    input  logic          i_busy,
    output tcw_pkg::t_slot o_push
);
    import tcw_pkg::*;

    t_op w_op;

    assign i_req.ready = !i_full && !i_busy;

    always_comb begin
        unique case (i_req.req_type)
            REQ_STRING: begin
                if (i_req.char_code == CH_TOGGLE) begin
                    w_op = OP_TOGGLE;
                end else if (i_req.char_code == CH_NUL) begin
                    w_op = OP_NOP;
                end else if (i_req.char_code == CH_NEWLINE) begin
                    w_op = OP_NEWLINE;
                end else begin
                    w_op = OP_CHAR;
                end
            end
            REQ_RAW: begin
                w_op = (i_req.char_code == CH_NEWLINE) ? OP_NEWLINE : OP_CHAR;
            end
            REQ_READ: begin
                // Reads outside the screen return an empty cell, as a no-op does.
                if (i_req.read_row <= LAST_ROW && i_req.read_col <= LAST_COL) begin
                    w_op = OP_READ;
                end else begin
                    w_op = OP_NOP;
                end
            end
            default: begin
                w_op = OP_NOP;
            end
        endcase
    end

    assign o_push.valid   = i_req.valid && i_req.ready;
    assign o_push.cmd.op  = w_op;
    assign o_push.cmd.ch  = i_req.char_code;
    assign o_push.cmd.row = i_req.read_row;
    assign o_push.cmd.col = i_req.read_col;

endmodule

// ===== sv/tcw_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on tcw_pkg.
module tcw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tcw_pkg::t_slot i_push,
    input  logic           i_pop,
    output logic           o_full,
    output tcw_pkg::t_slot o_head
);
    import tcw_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push.valid && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_q[r_wr_ptr] <= i_push.cmd;
        end
    end

    assign o_full       = (r_count == 2'd2);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.cmd   = r_q[r_rd_ptr];

endmodule

// ===== sv/tcw_back.sv =====
// Back end: cursor, bright flag, cell memory with rotating top row, and result register.
// Depends on tcw_pkg, tcw_res_if and assert_macros.svh.
`include "assert_macros.svh"

module tcw_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tcw_pkg::t_slot i_head,
    input  tcw_pkg::t_attr i_attr,
    output logic           o_pop,
    output logic           o_busy,
    tcw_res_if.source      o_res
);
    import tcw_pkg::*;

    localparam logic [1:0] ST_INIT  = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_CLEAR = 2'd3;

    // Physical row of a screen row, given the physical row now shown on top.
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] base);
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, base};
        if (sum >= (ROW_W + 1)'(SCREEN_ROWS)) begin
            sum = sum - (ROW_W + 1)'(SCREEN_ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] base);
        return ADDR_W'(phys_row(row, base)) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col);
    endfunction

    logic [15:0]       r_cells [CELLS];
    logic [15:0]       r_rd_data;
    logic [1:0]        r_state, n_state;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_bright, n_bright;
    logic [ROW_W-1:0]  r_base, n_base;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [ADDR_W-1:0] r_clr_end, n_clr_end;
    logic              r_out_valid, n_out_valid;
    t_res              r_out, n_out;

    logic              w_out_free;
    logic              w_take;
    logic              w_emit;
    logic              w_emit_scroll;
    logic [15:0]       w_emit_cell;
    logic              w_wrap;
    logic [ADDR_W-1:0] w_row_start;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [15:0]       w_wdata;
    logic [ADDR_W-1:0] w_raddr;

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_take      = (r_state == ST_IDLE) && i_head.valid && w_out_free;
    assign o_pop       = w_take;
    assign o_busy      = (r_state == ST_INIT);
    assign w_row_start = ADDR_W'(r_base) * ADDR_W'(SCREEN_COLS);
    assign w_wrap      = (i_head.cmd.op == OP_NEWLINE) ||
                         (i_head.cmd.op == OP_CHAR && r_col == LAST_COL);
    assign w_raddr     = cell_addr(i_head.cmd.row, i_head.cmd.col, r_base);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr_addr;
        w_wdata = '0;
        if (r_state == ST_INIT || r_state == ST_CLEAR) begin
            w_we = 1'b1;
        end else if (w_take && i_head.cmd.op == OP_CHAR) begin
            w_we    = 1'b1;
            w_waddr = cell_addr(r_row, r_col, r_base);
            w_wdata = {(r_bright ? i_attr.bright : i_attr.normal), i_head.cmd.ch};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_cells[w_waddr] <= w_wdata;
        end
        if (r_state == ST_IDLE) begin
            r_rd_data <= r_cells[w_raddr];
        end
    end

    always_comb begin
        n_state       = r_state;
        n_col         = r_col;
        n_row         = r_row;
        n_bright      = r_bright;
        n_base        = r_base;
        n_clr_addr    = r_clr_addr;
        n_clr_end     = r_clr_end;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_out         = r_out;
        w_emit        = 1'b0;
        w_emit_scroll = 1'b0;
        w_emit_cell   = '0;

        unique case (r_state)
            ST_INIT: begin
                if (r_clr_addr == r_clr_end) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (w_take) begin
                    unique case (i_head.cmd.op)
                        OP_READ: begin
                            n_state = ST_READ;
                        end
                        OP_TOGGLE: begin
                            n_bright = ~r_bright;
                            w_emit   = 1'b1;
                        end
                        OP_CHAR, OP_NEWLINE: begin
                            if (w_wrap) begin
                                n_col = '0;
                                if (r_row == LAST_ROW) begin
                                    // Scroll: the top physical row becomes the new
                                    // bottom row and is cleared before the result.
                                    n_base     = (r_base == LAST_ROW) ? '0
                                                                      : r_base + ROW_W'(1);
                                    n_clr_addr = w_row_start;
                                    n_clr_end  = w_row_start + ADDR_W'(SCREEN_COLS - 1);
                                    n_state    = ST_CLEAR;
                                end else begin
                                    n_row  = r_row + ROW_W'(1);
                                    w_emit = 1'b1;
                                end
                            end else begin
                                n_col  = r_col + COL_W'(1);
                                w_emit = 1'b1;
                            end
                        end
                        default: begin
                            w_emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_emit_cell = r_rd_data;
                    n_state     = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                if (r_clr_addr == r_clr_end) begin
                    if (w_out_free) begin
                        w_emit        = 1'b1;
                        w_emit_scroll = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end else begin
                    n_clr_addr = r_clr_addr + ADDR_W'(1);
                end
            end
        endcase

        if (w_emit) begin
            n_out_valid      = 1'b1;
            n_out.cursor_col = n_col;
            n_out.cursor_row = n_row;
            n_out.bright_on  = n_bright;
            n_out.did_scroll = w_emit_scroll;
            n_out.cell_char  = w_emit_cell[7:0];
            n_out.cell_attr  = w_emit_cell[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_col       <= '0;
            r_row       <= '0;
            r_bright    <= 1'b0;
            r_base      <= '0;
            r_clr_addr  <= '0;
            r_clr_end   <= ADDR_W'(CELLS - 1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_bright    <= n_bright;
            r_base      <= n_base;
            r_clr_addr  <= n_clr_addr;
            r_clr_end   <= n_clr_end;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.cursor_col = r_out.cursor_col;
    assign o_res.cursor_row = r_out.cursor_row;
    assign o_res.bright_on  = r_out.bright_on;
    assign o_res.did_scroll = r_out.did_scroll;
    assign o_res.cell_char  = r_out.cell_char;
    assign o_res.cell_attr  = r_out.cell_attr;

    `TCW_ASSERT(a_cursor_on_screen, (r_col <= LAST_COL) && (r_row <= LAST_ROW), "cursor left the screen")
    `TCW_ASSERT(a_base_in_range, r_base <= LAST_ROW, "top row pointer out of range")
    `TCW_ASSERT_IMPL(a_init_quiet, r_state == ST_INIT, !r_out_valid && !o_pop, "activity during clear")
    `TCW_ASSERT_IMPL(a_scroll_cursor, r_out_valid && r_out.did_scroll, (r_out.cursor_row == LAST_ROW) && (r_out.cursor_col == '0), "scroll left cursor off the bottom row start")

endmodule
